// ===== hdl/lcc_pkg.sv =====
// Shared constants, types and a byte-range helper for the line charset classifier.
package lcc_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CLASS_W   = 2;
  localparam int unsigned PEND_W    = 3;
  localparam int unsigned OUT_TDATA_W = 8;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [CLASS_W-1:0] class_t;
  typedef logic [PEND_W-1:0]  pend_t;

  // Line class codes
  localparam class_t CLS_NONE  = 2'd0;
  localparam class_t CLS_SJIS  = 2'd1;
  localparam class_t CLS_EUCKR = 2'd2;
  localparam class_t CLS_UTF8  = 2'd3;

  // Byte range bounds
  localparam byte_t B_ASCII_MAX  = 8'h7f;
  localparam byte_t B_KANA_LO    = 8'ha1;
  localparam byte_t B_KANA_HI    = 8'hdf;
  localparam byte_t B_SJ_LEAD1_LO = 8'h81;
  localparam byte_t B_SJ_LEAD1_HI = 8'h9f;
  localparam byte_t B_SJ_LEAD2_LO = 8'he0;
  localparam byte_t B_SJ_LEAD2_HI = 8'hef;
  localparam byte_t B_SJ_LEAD3_LO = 8'hf0;
  localparam byte_t B_SJ_LEAD3_HI = 8'hfc;
  localparam byte_t B_SJ_TR1_LO  = 8'h40;
  localparam byte_t B_SJ_TR1_HI  = 8'h7e;
  localparam byte_t B_SJ_TR2_LO  = 8'h80;
  localparam byte_t B_KR_LO      = 8'ha1;
  localparam byte_t B_KR_HI      = 8'hfe;
  localparam byte_t B_KR_SS2     = 8'h8e;
  localparam byte_t B_KR_SS3     = 8'h8f;

  // Output beat layout (lowest bit up)
  localparam int unsigned OB_CLASS_LO = 0;
  localparam int unsigned OB_SJIS     = 2;
  localparam int unsigned OB_EUCKR    = 3;
  localparam int unsigned OB_UTF8     = 4;

  function automatic logic in_range(input byte_t b, input byte_t lo, input byte_t hi);
    in_range = (b >= lo) && (b <= hi);
  endfunction

endpackage

// ===== hdl/line_charset_classifier_core.sv =====
// Line charset classifier: Shift-JIS, EUC-KR and UTF-8 validators with end-of-line verdict.
// An end-of-line beat is held in the input register stage, then its verdict in the result register.
// Throughput: one beat per cycle; the only stall is a result waiting on out_tready.
// Data-byte beats produce no result; each updates the validator state.
// Reset (rst_n low, synchronous): pipeline emptied, all validators cleared to good/idle.
module line_charset_classifier_core
  import lcc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [BYTE_W-1:0]      in_tdata,   // [7:0] data_byte
  input  logic                   in_tlast,   // func: 1 = end of line
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [1:0] line_class, [2] sjis_valid,
                                             // [3] euckr_valid, [4] utf8_valid, [7:5] 0
);

  // Input register stage
  logic  s1_valid_r, s1_valid_nxt;
  logic  s1_eol_r;
  byte_t s1_byte_r;

  // Validator state
  logic  sjis_await_r, sjis_await_nxt;
  logic  sjis_good_r,  sjis_good_nxt;
  logic  kr_await_r,   kr_await_nxt;
  logic  kr_good_r,    kr_good_nxt;
  pend_t u8_pend_r,    u8_pend_nxt;
  logic  u8_good_r,    u8_good_nxt;

  // Result register
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r,  out_data_nxt;

  logic  out_free, s1_fire, in_fire;
  logic  v_sjis, v_kr, v_u8;
  class_t cls;
  byte_t b;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && (!s1_eol_r || out_free);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;
  assign b         = s1_byte_r;

  assign v_sjis = sjis_good_r && !sjis_await_r;
  assign v_kr   = kr_good_r && !kr_await_r;
  assign v_u8   = u8_good_r && (u8_pend_r == '0);

  always_comb begin
    if (v_sjis) begin
      cls = CLS_SJIS;
    end else if (v_kr) begin
      cls = CLS_EUCKR;
    end else if (v_u8) begin
      cls = CLS_UTF8;
    end else begin
      cls = CLS_NONE;
    end
  end

  always_comb begin
    sjis_await_nxt = sjis_await_r;
    sjis_good_nxt  = sjis_good_r;
    kr_await_nxt   = kr_await_r;
    kr_good_nxt    = kr_good_r;
    u8_pend_nxt    = u8_pend_r;
    u8_good_nxt    = u8_good_r;

    if (s1_fire && s1_eol_r) begin
      // line done: back to reset values
      sjis_await_nxt = 1'b0;
      sjis_good_nxt  = 1'b1;
      kr_await_nxt   = 1'b0;
      kr_good_nxt    = 1'b1;
      u8_pend_nxt    = '0;
      u8_good_nxt    = 1'b1;
    end else if (s1_fire) begin
      // Shift-JIS
      if (sjis_await_r) begin
        sjis_await_nxt = 1'b0;
        if (!(in_range(b, B_SJ_TR1_LO, B_SJ_TR1_HI) ||
              in_range(b, B_SJ_TR2_LO, B_SJ_LEAD3_HI))) begin
          sjis_good_nxt = 1'b0;
        end
      end else if (b <= B_ASCII_MAX || in_range(b, B_KANA_LO, B_KANA_HI)) begin
        sjis_await_nxt = 1'b0;
      end else if (in_range(b, B_SJ_LEAD1_LO, B_SJ_LEAD1_HI) ||
                   in_range(b, B_SJ_LEAD2_LO, B_SJ_LEAD2_HI) ||
                   in_range(b, B_SJ_LEAD3_LO, B_SJ_LEAD3_HI)) begin
        sjis_await_nxt = 1'b1;
      end else begin
        sjis_good_nxt = 1'b0;
      end

      // EUC-KR
      if (kr_await_r) begin
        kr_await_nxt = 1'b0;
        if (!in_range(b, B_KR_LO, B_KR_HI)) begin
          kr_good_nxt = 1'b0;
        end
      end else if (b <= B_ASCII_MAX) begin
        kr_await_nxt = 1'b0;
      end else if (b == B_KR_SS2 || b == B_KR_SS3) begin
        kr_good_nxt = 1'b0;
      end else if (in_range(b, B_KR_LO, B_KR_HI)) begin
        kr_await_nxt = 1'b1;
      end else begin
        kr_good_nxt = 1'b0;
      end

      // UTF-8
      if (u8_pend_r != '0) begin
        u8_pend_nxt = u8_pend_r - pend_t'(1);
        if (b[7:6] != 2'b10) begin
          u8_good_nxt = 1'b0;
        end
      end else if (!b[7]) begin
        u8_pend_nxt = '0;
      end else if (b[7:5] == 3'b110) begin
        u8_pend_nxt = pend_t'(1);
      end else if (b[7:4] == 4'b1110) begin
        u8_pend_nxt = pend_t'(2);
      end else if (b[7:3] == 5'b11110) begin
        u8_pend_nxt = pend_t'(3);
      end else if (b[7:2] == 6'b111110) begin
        u8_pend_nxt = pend_t'(4);
      end else if (b[7:1] == 7'b1111110) begin
        u8_pend_nxt = pend_t'(5);
      end else begin
        u8_good_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    s1_valid_nxt  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    if (s1_fire && s1_eol_r) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      out_data_nxt[OB_CLASS_LO +: CLASS_W] = cls;
      out_data_nxt[OB_SJIS]  = v_sjis;
      out_data_nxt[OB_EUCKR] = v_kr;
      out_data_nxt[OB_UTF8]  = v_u8;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      sjis_await_r <= 1'b0;
      sjis_good_r  <= 1'b1;
      kr_await_r   <= 1'b0;
      kr_good_r    <= 1'b1;
      u8_pend_r    <= '0;
      u8_good_r    <= 1'b1;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      sjis_await_r <= sjis_await_nxt;
      sjis_good_r  <= sjis_good_nxt;
      kr_await_r   <= kr_await_nxt;
      kr_good_r    <= kr_good_nxt;
      u8_pend_r    <= u8_pend_nxt;
      u8_good_r    <= u8_good_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_tdata;
      s1_eol_r  <= in_tlast;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hdl/lcc_checker.sv =====
// Port-level checker for the line charset classifier, bound to the top level.
module lcc_checker
  import lcc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [BYTE_W-1:0]      in_tdata,
  input logic                   in_tlast,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [CLASS_W-1:0] o_cls;
  assign o_cls = out_tdata[OB_CLASS_LO +: CLASS_W];

  // Offered input beat holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable({in_tlast, in_tdata}))
    else $error("input beat changed while waiting");

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // Class follows the verdict bits by priority
  a_class_prio: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      (out_tdata[OB_SJIS] ? (o_cls == CLS_SJIS) :
       out_tdata[OB_EUCKR] ? (o_cls == CLS_EUCKR) :
       out_tdata[OB_UTF8] ? (o_cls == CLS_UTF8) : (o_cls == CLS_NONE)))
    else $error("line class does not match verdicts");

  // Pad bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:OB_UTF8+1] == '0)
    else $error("pad bits set in result beat");

  // Reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind line_charset_classifier_core lcc_checker u_lcc_checker (.*);
